// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment command sequencer
// Bus symbol kinds, command byte values, internal command codes, the queue
// entry that travels from front to back, and the digit glyph table.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int NUM_DIGITS_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	// bus symbol kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// request codes on the input word
	localparam logic [2:0] REQ_INIT      = 3'd0;
	localparam logic [2:0] REQ_DIGIT     = 3'd1;
	localparam logic [2:0] REQ_NUMBER    = 3'd2;
	localparam logic [2:0] REQ_RAW       = 3'd3;
	localparam logic [2:0] REQ_SET_COLON = 3'd4;
	localparam logic [2:0] REQ_TOG_COLON = 3'd5;
	localparam logic [2:0] REQ_CLEAR     = 3'd6;
	localparam logic [2:0] REQ_CLEAR_POS = 3'd7;

	// classified commands handed to the back end
	localparam logic [2:0] CMD_INIT   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_NUMBER = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_CSET   = 3'd4;
	localparam logic [2:0] CMD_CTOG   = 3'd5;

	// driver chip command bytes
	localparam logic [7:0] CTL_DISPLAY_ON = 8'h8F;
	localparam logic [7:0] CTL_AUTO_ADDR  = 8'h40;
	localparam logic [7:0] CTL_FIXED_ADDR = 8'h44;
	localparam logic [7:0] CTL_ADDR_BASE  = 8'hC0;
	localparam logic [7:0] COLON_MASK     = 8'h80;
	localparam logic [7:0] SEG_MASK       = 8'h7F;

	localparam int GLYPH_COUNT = 18;

	// decimal split: floor(n / 1000) = (n * RECIP_1000) >> RECIP_SHIFT, n < 2**16
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam int          RECIP_SHIFT = 26;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [7:0]      pos;
		logic [7:0]      seg;
		logic            colon;
		logic [3:0][7:0] dig;   // dig[0] goes to position 1
	} ssd_entry_t;

	function automatic logic [7:0] glyph(input logic [7:0] code);
		logic [7:0] s;
		unique case (code)
			8'd0:    s = 8'h3f;
			8'd1:    s = 8'h06;
			8'd2:    s = 8'h5b;
			8'd3:    s = 8'h4f;
			8'd4:    s = 8'h66;
			8'd5:    s = 8'h6d;
			8'd6:    s = 8'h7d;
			8'd7:    s = 8'h07;
			8'd8:    s = 8'h7f;
			8'd9:    s = 8'h6f;
			8'd10:   s = 8'h77;
			8'd11:   s = 8'h7c;
			8'd12:   s = 8'h39;
			8'd13:   s = 8'h5e;
			8'd14:   s = 8'h79;
			8'd15:   s = 8'h71;
			8'd16:   s = 8'h40;
			default: s = 8'h00;   // code 17 and every code past the table: blank
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ssd_queue.sv =====
// ----------------------------------------------------------------------------
// ssd_queue: command queue between front and back
// Small first-in first-out buffer of classified command entries.
// ----------------------------------------------------------------------------
module ssd_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ssd_pkg::ssd_entry_t din,
	input  logic               pop,
	output ssd_pkg::ssd_entry_t dout,
	output logic               full,
	output logic               empty
);
	import ssd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssd_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front: request intake and classification
// Three-stage pipeline: splits the number into decimal digits, looks up
// glyphs, drops colon edits at an invalid position and pushes commands.
// ----------------------------------------------------------------------------
module ssd_front #(
	parameter int NUM_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic [7:0]         pos,
	input  logic [7:0]         digit_code,
	input  logic               colon_flag,
	input  logic [7:0]         segment_byte,
	input  logic [15:0]        number,
	input  logic               q_full,
	output logic               q_push,
	output ssd_pkg::ssd_entry_t q_entry
);
	import ssd_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic ld1, ld2, ld3, mv1, mv2, mv3;
	logic keep;

	logic [2:0]  req_s1, req_s2, req_s3;
	logic [7:0]  pos_s1, pos_s2, pos_s3;
	logic [7:0]  code_s1, code_s2, code_s3;
	logic        colon_s1, colon_s2, colon_s3;
	logic [7:0]  raw_s1, raw_s2, raw_s3;
	logic [15:0] num_s1;
	logic [32:0] prod_s1;
	logic [6:0]  d1_s2, d1_s3;
	logic [9:0]  r1_s2;
	logic [3:0]  h_s3;
	logic [6:0]  r2_s3;

	logic [6:0]  d1;
	logic [15:0] r1_full;
	logic [8:0]  ge100;
	logic [3:0]  h;
	logic [9:0]  r2_full;
	logic [8:0]  ge10;
	logic [3:0]  t;
	logic [6:0]  u_full;
	logic        pos_ok;
	ssd_entry_t  e;

	// pipeline flow: a stage loads when empty or when it hands on its word
	assign mv3 = v_s3 && !(keep && q_full);
	assign ld3 = !v_s3 || mv3;
	assign mv2 = v_s2 && ld3;
	assign ld2 = !v_s2 || mv2;
	assign mv1 = v_s1 && ld2;
	assign ld1 = !v_s1 || mv1;

	assign req_stall = !ld1;
	assign q_push    = v_s3 && keep && !q_full;
	assign q_entry   = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= req_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 2 and 3 digit math
	always_comb begin
		d1      = prod_s1[RECIP_SHIFT+6:RECIP_SHIFT];
		r1_full = num_s1 - 16'({9'b0, d1} * 16'd1000);
		for (int k = 1; k <= 9; k++) begin
			ge100[k-1] = (r1_s2 >= 10'(k * 100));
		end
		h       = 4'($countones(ge100));
		r2_full = r1_s2 - 10'({6'b0, h} * 10'd100);
		for (int k = 1; k <= 9; k++) begin
			ge10[k-1] = (r2_s3 >= 7'(k * 10));
		end
		t      = 4'($countones(ge10));
		u_full = r2_s3 - 7'({3'b0, t} * 7'd10);
	end

	always_ff @(posedge clk) begin
		if (ld1 && req_valid) begin
			req_s1   <= req_type;
			pos_s1   <= pos;
			code_s1  <= digit_code;
			colon_s1 <= colon_flag;
			raw_s1   <= segment_byte;
			num_s1   <= number;
			prod_s1  <= 33'(number) * 33'(RECIP_1000);
		end
		if (mv1) begin
			req_s2   <= req_s1;
			pos_s2   <= pos_s1;
			code_s2  <= code_s1;
			colon_s2 <= colon_s1;
			raw_s2   <= raw_s1;
			d1_s2    <= d1;
			r1_s2    <= r1_full[9:0];
		end
		if (mv2) begin
			req_s3   <= req_s2;
			pos_s3   <= pos_s2;
			code_s3  <= code_s2;
			colon_s3 <= colon_s2;
			raw_s3   <= raw_s2;
			d1_s3    <= d1_s2;
			h_s3     <= h;
			r2_s3    <= r2_full[6:0];
		end
	end

	// classify
	assign pos_ok = (pos_s3 != 8'd0) && (pos_s3 <= 8'(NUM_DIGITS));

	always_comb begin
		e.cmd    = CMD_WRITE;
		e.pos    = pos_s3;
		e.seg    = 8'h00;
		e.colon  = colon_s3;
		e.dig[0] = glyph({1'b0, d1_s3});
		e.dig[1] = glyph({4'b0, h_s3}) | (colon_s3 ? COLON_MASK : 8'h00);
		e.dig[2] = glyph({4'b0, t});
		e.dig[3] = glyph({4'b0, u_full[3:0]});
		keep     = 1'b1;
		unique case (req_s3)
			REQ_INIT:      e.cmd = CMD_INIT;
			REQ_DIGIT:     e.seg = glyph(code_s3) | (colon_s3 ? COLON_MASK : 8'h00);
			REQ_NUMBER:    e.cmd = CMD_NUMBER;
			REQ_RAW:       e.seg = raw_s3;
			REQ_SET_COLON: begin
				e.cmd = CMD_CSET;
				keep  = pos_ok;
			end
			REQ_TOG_COLON: begin
				e.cmd = CMD_CTOG;
				keep  = pos_ok;
			end
			REQ_CLEAR:     e.cmd = CMD_CLEAR;
			REQ_CLEAR_POS: e.seg = 8'h00;
			default:       e.cmd = CMD_WRITE;
		endcase
	end

endmodule

// ===== rtl/ssd_back.sv =====
// ----------------------------------------------------------------------------
// ssd_back: symbol sequencer
// Pops a command, updates the shadow segment buffer and steps through the
// start / byte / stop symbols of the command, one per cycle unless sym_stall holds it.
// ----------------------------------------------------------------------------
module ssd_back #(
	parameter int NUM_DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ssd_pkg::ssd_entry_t q_head,
	output logic               q_pop,
	output logic               sym_valid,
	input  logic               sym_stall,
	output logic [1:0]         symbol_kind,
	output logic [7:0]         byte_value,
	output logic               last
);
	import ssd_pkg::*;

	localparam int SIW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	logic [7:0]      shadow_q [NUM_DIGITS];
	logic            busy_q;
	logic [2:0]      cmd_q;
	logic [7:0]      pos_q;
	logic [7:0]      seg_q;
	logic [3:0][7:0] dig_q;
	logic [1:0]      grp_q;
	logic [4:0]      idx_q;
	logic            out_v_q;
	logic [1:0]      kind_q;
	logic [7:0]      byte_q;
	logic            last_q;

	logic            adv;
	logic [SIW-1:0]  sh_idx;
	logic [7:0]      sh;
	logic [7:0]      new_seg;
	logic            wr_like;
	logic [7:0]      cur_pos;
	logic [7:0]      cur_seg;
	logic [4:0]      clr_idx;
	logic [1:0]      s_kind;
	logic [7:0]      s_byte;
	logic            s_last;

	assign sym_valid   = out_v_q;
	assign symbol_kind = kind_q;
	assign byte_value  = byte_q;
	assign last        = last_q;

	assign adv   = busy_q && (!out_v_q || !sym_stall);
	assign q_pop = !q_empty && (!busy_q || (adv && s_last));

	// colon edits read the shadow byte at pop time
	always_comb begin
		sh_idx  = SIW'(q_head.pos - 8'd1);
		sh      = shadow_q[sh_idx];
		wr_like = (q_head.cmd == CMD_WRITE) || (q_head.cmd == CMD_CSET) ||
			(q_head.cmd == CMD_CTOG);
		case (q_head.cmd)
			CMD_CSET: new_seg = (sh & SEG_MASK) | (q_head.colon ? COLON_MASK : 8'h00);
			CMD_CTOG: new_seg = sh ^ COLON_MASK;
			default:  new_seg = q_head.seg;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				shadow_q[i] <= 8'h00;
			end
		end else if (q_pop) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (q_head.cmd == CMD_NUMBER) begin
					if (i < 4) begin
						shadow_q[i] <= q_head.dig[2'(i)];
					end
				end else if (wr_like && q_head.pos == 8'(i + 1)) begin
					shadow_q[i] <= new_seg;
				end
			end
		end
	end

	// symbol generator
	always_comb begin
		cur_pos = (cmd_q == CMD_NUMBER) ? {6'b0, grp_q} + 8'd1 : pos_q;
		cur_seg = (cmd_q == CMD_NUMBER) ? dig_q[grp_q] : seg_q;
		clr_idx = (cmd_q == CMD_INIT) ? idx_q - 5'd6 : idx_q;
		s_kind  = KIND_BYTE;
		s_byte  = 8'h00;
		s_last  = 1'b0;
		unique case (cmd_q) inside
			CMD_INIT, CMD_CLEAR: begin
				if (cmd_q == CMD_INIT && idx_q < 5'd6) begin
					if (idx_q == 5'd0 || idx_q == 5'd3) begin
						s_kind = KIND_START;
					end else if (idx_q == 5'd2 || idx_q == 5'd5) begin
						s_kind = KIND_STOP;
					end else begin
						s_byte = (idx_q < 5'd3) ? CTL_DISPLAY_ON : CTL_AUTO_ADDR;
					end
				end else if (clr_idx == 5'd0 || clr_idx == 5'd3) begin
					s_kind = KIND_START;
				end else if (clr_idx == 5'd2) begin
					s_kind = KIND_STOP;
				end else if (clr_idx == 5'd1) begin
					s_byte = CTL_AUTO_ADDR;
				end else if (clr_idx == 5'd4) begin
					s_byte = CTL_ADDR_BASE;
				end else if (clr_idx == 5'(5 + NUM_DIGITS)) begin
					s_kind = KIND_STOP;
					s_last = 1'b1;
				end
			end
			CMD_WRITE, CMD_NUMBER, CMD_CSET, CMD_CTOG: begin
				case (idx_q)
					5'd0, 5'd3: s_kind = KIND_START;
					5'd1:       s_byte = CTL_FIXED_ADDR;
					5'd2:       s_kind = KIND_STOP;
					5'd4:       s_byte = CTL_ADDR_BASE | (cur_pos - 8'd1);
					5'd5:       s_byte = cur_seg;
					default: begin
						s_kind = KIND_STOP;
						s_last = (cmd_q != CMD_NUMBER) || (grp_q == 2'd3);
					end
				endcase
			end
			default: begin
				s_kind = KIND_STOP;
				s_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (adv && s_last) begin
				busy_q <= 1'b0;
			end
			if (!out_v_q || !sym_stall) begin
				out_v_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head.cmd;
			pos_q <= q_head.pos;
			seg_q <= new_seg;
			dig_q <= q_head.dig;
			grp_q <= 2'd0;
			idx_q <= 5'd0;
		end else if (adv) begin
			if (cmd_q == CMD_NUMBER && idx_q == 5'd6) begin
				idx_q <= 5'd0;
				grp_q <= grp_q + 2'd1;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
		if (adv) begin
			kind_q <= s_kind;
			byte_q <= s_byte;
			last_q <= s_last;
		end
	end

endmodule

// ===== rtl/seven_segment_display_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_command_sequencer: display command to bus symbols
// Turns one display command into the start, byte and stop symbols of a
// two-wire seven-segment driver chip, keeping a shadow copy of the segments.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   req_type pos digit_code colon_flag
//                                             segment_byte number
//   sym      out        sym_valid/sym_stall   symbol_kind byte_value last
//
// The back end emits one symbol per cycle from its output register while
// sym_stall is low; a number command writes its digits one at a time, clear
// writes every position in one run and init turns the display on, then clears.
// Reset clears the shadow buffer, the queue and all valid flags at once.
// Stalls on sym hold the output word; the queue lets req keep flowing until
// it fills. Colon edits at an invalid position produce no symbols.
// ----------------------------------------------------------------------------
module seven_segment_display_command_sequencer #(
	parameter int NUM_DIGITS  = ssd_pkg::NUM_DIGITS_DEF,
	parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  pos,
	input  logic [7:0]  digit_code,
	input  logic        colon_flag,
	input  logic [7:0]  segment_byte,
	input  logic [15:0] number,
	output logic        sym_valid,
	input  logic        sym_stall,
	output logic [1:0]  symbol_kind,
	output logic [7:0]  byte_value,
	output logic        last
);
	import ssd_pkg::*;

	// front to queue
	logic       q_push;
	logic       q_full;
	ssd_entry_t q_in;
	// queue to back
	logic       q_pop;
	logic       q_empty;
	ssd_entry_t q_head;

	// intake: split digits, look up glyphs, drop colon edits at an invalid position
	ssd_front #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.pos         (pos),
		.digit_code  (digit_code),
		.colon_flag  (colon_flag),
		.segment_byte(segment_byte),
		.number      (number),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	// decouple intake from the slow symbol stream
	ssd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.pop   (q_pop),
		.dout  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	// sequence symbols and maintain the shadow segments
	ssd_back #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.symbol_kind(symbol_kind),
		.byte_value (byte_value),
		.last       (last)
	);

	// every command ends on a stop condition
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && last |-> symbol_kind == KIND_STOP)
		else $error("last word is not a stop condition");

	// start and stop carry a zero byte
	a_ctl_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && symbol_kind != KIND_BYTE |-> byte_value == 8'h00)
		else $error("nonzero byte on start or stop");

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue overflow");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

endmodule
